FILE: design/cvfa_pkg.sv
package cvfa_pkg;

	localparam int ModuleCount    = 12;
	localparam int CellsPerModule = 8;
	localparam int Lanes          = 4;
	localparam int BankRows       = ModuleCount * CellsPerModule / Lanes;
	localparam int RowW           = (BankRows > 1) ? $clog2(BankRows) : 1;

	localparam int VoltW   = 16;
	localparam int ScaledW = 19;
	localparam int FracW   = 27;
	localparam int QuotW   = 13;
	localparam int RecipW  = 28;
	localparam int ProdW   = FracW + RecipW;

	localparam logic [28:0] IdLow     = 29'h300;
	localparam logic [28:0] IdHigh    = 29'h320;
	localparam logic [6:0]  FrameLen  = 7'd8;

	// raw * 6.1035 = raw * 6 + raw * 1035 / 10000
	localparam logic [10:0]       ScaleFrac  = 11'd1035;
	localparam logic [RecipW-1:0] RecipM     = 28'd219902326;
	localparam int                RecipShift = 41;

	localparam logic [VoltW-1:0] LowLimitRst  = 16'd23000;
	localparam logic [VoltW-1:0] HighLimitRst = 16'd40000;

	typedef enum logic [0:0] {
		REG_LOW_LIMIT  = 1'b0,
		REG_HIGH_LIMIT = 1'b1
	} cvfa_reg_t;

	typedef struct packed {
		logic             en;
		logic [RowW-1:0]  row;
		logic [VoltW-1:0] data;
	} cvfa_wr_t;

	function automatic logic [3:0] mod_module(input logic [3:0] v);
		logic [3:0] r;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			if (v == 4'(i)) begin
				r = 4'(i % ModuleCount);
			end
		end
		return r;
	endfunction

endpackage

FILE: design/cell_voltage_frame_averager.sv
// channel   direction  handshake             beat
// in        input      in_valid / in_ready   frame_id, data_length, byte0..byte7
// out       output     out_valid / out_ready accepted, module_number, first_cell,
//                                            updated_mask, stored_value0..3
// cfg       input      cfg_wr_en             cfg_index, cfg_wdata
//
// One frame per cycle sustained while out_ready is high; on its way to the result,
// the beat lands in the read stage, then the scale stage, then the output register.
// Cells sit in four banks, one per payload value, read at input and written back
// from the scale stage, with forwarding of every write into the waiting entries.
// Reset clears the per-entry valid bits at once: no clearing pass, in_ready is high
// right after reset. While out_ready is low the output holds and up to two more
// frames queue behind it before in_ready drops.
module cell_voltage_frame_averager (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [0:0]                  cfg_index,
	input  logic [15:0]                 cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [28:0]                 frame_id,
	input  logic [6:0]                  data_length,
	input  logic [7:0]                  byte0,
	input  logic [7:0]                  byte1,
	input  logic [7:0]                  byte2,
	input  logic [7:0]                  byte3,
	input  logic [7:0]                  byte4,
	input  logic [7:0]                  byte5,
	input  logic [7:0]                  byte6,
	input  logic [7:0]                  byte7,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        accepted,
	output logic [3:0]                  module_number,
	output logic [2:0]                  first_cell,
	output logic [3:0]                  updated_mask,
	output logic [15:0]                 stored_value0,
	output logic [15:0]                 stored_value1,
	output logic [15:0]                 stored_value2,
	output logic [15:0]                 stored_value3
);
	import cvfa_pkg::*;

	logic [VoltW-1:0] low_limit_q;
	logic [VoltW-1:0] high_limit_q;

	logic in_fire;
	logic s1_v_q, s2_v_q, out_valid_q;
	logic s1_move, s2_move;

	logic             ok_d;
	logic [3:0]       mod_d;
	logic [RowW-1:0]  row_d;
	logic [VoltW-1:0] raw_d  [Lanes];
	logic [FracW-1:0] frac_d [Lanes];

	logic               ok_s1;
	logic [3:0]         mod_s1;
	logic               sel_s1;
	logic [RowW-1:0]    row_s1;
	logic [VoltW-1:0]   raw_s1  [Lanes];
	logic [FracW-1:0]   frac_s1 [Lanes];
	logic [Lanes-1:0]   hit_s1;
	logic [VoltW-1:0]   fwd_s1  [Lanes];
	logic [VoltW-1:0]   rd_data [Lanes];
	logic [VoltW-1:0]   old_s1  [Lanes];
	logic [ProdW-1:0]   prod_s1 [Lanes];

	logic               ok_s2;
	logic [3:0]         mod_s2;
	logic               sel_s2;
	logic [RowW-1:0]    row_s2;
	logic [ScaledW-1:0] raw6_s2 [Lanes];
	logic [QuotW-1:0]   quot_s2 [Lanes];
	logic [VoltW-1:0]   old_s2  [Lanes];

	logic [ScaledW-1:0] scaled   [Lanes];
	logic [VoltW:0]     sum      [Lanes];
	logic [VoltW-1:0]   new_val  [Lanes];
	logic [VoltW-1:0]   stored   [Lanes];
	logic [Lanes-1:0]   in_rng;
	cvfa_wr_t           wr       [Lanes];

	logic             accepted_q;
	logic [3:0]       module_number_q;
	logic [2:0]       first_cell_q;
	logic [3:0]       updated_mask_q;
	logic [VoltW-1:0] stored_q [Lanes];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q  <= LowLimitRst;
			high_limit_q <= HighLimitRst;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LOW_LIMIT:  low_limit_q  <= cfg_wdata;
				REG_HIGH_LIMIT: high_limit_q <= cfg_wdata;
			endcase
		end
	end

	assign s2_move  = s2_v_q && (!out_valid_q || out_ready);
	assign s1_move  = s1_v_q && (!s2_v_q || s2_move);
	assign in_ready = !s1_v_q || s1_move;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q      <= 1'b0;
			s2_v_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				s1_v_q <= 1'b1;
			end else if (s1_move) begin
				s1_v_q <= 1'b0;
			end
			if (s1_move) begin
				s2_v_q <= 1'b1;
			end else if (s2_move) begin
				s2_v_q <= 1'b0;
			end
			if (s2_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign ok_d  = (frame_id >= IdLow) && (frame_id <= IdHigh) && (data_length == FrameLen);
	assign mod_d = mod_module(frame_id[3:0]);
	assign row_d = RowW'({mod_d, frame_id[4]});

	assign raw_d[0] = {byte1, byte0};
	assign raw_d[1] = {byte3, byte2};
	assign raw_d[2] = {byte5, byte4};
	assign raw_d[3] = {byte7, byte6};

	for (genvar k = 0; k < Lanes; k++) begin : g_lane
		assign frac_d[k] = FracW'(raw_d[k]) * FracW'(ScaleFrac);

		cvfa_bank u_bank (
			.clk     (clk),
			.arst_n  (arst_n),
			.rd_en   (in_fire),
			.rd_row  (row_d),
			.wr      (wr[k]),
			.rd_data (rd_data[k])
		);

		assign old_s1[k]  = hit_s1[k] ? fwd_s1[k] : rd_data[k];
		assign prod_s1[k] = ProdW'(frac_s1[k]) * ProdW'(RecipM);

		assign scaled[k]  = raw6_s2[k] + ScaledW'(quot_s2[k]);
		assign in_rng[k]  = ok_s2 && (scaled[k] > ScaledW'(low_limit_q))
			&& (scaled[k] < ScaledW'(high_limit_q));
		assign sum[k]     = (VoltW + 1)'(old_s2[k]) + (VoltW + 1)'(scaled[k][VoltW-1:0]);
		assign new_val[k] = (old_s2[k] != '0) ? sum[k][VoltW:1] : scaled[k][VoltW-1:0];
		assign stored[k]  = in_rng[k] ? new_val[k] : old_s2[k];

		assign wr[k].en   = s2_move && in_rng[k];
		assign wr[k].row  = row_s2;
		assign wr[k].data = new_val[k];

		// catch write-backs that land after the bank read
		always_ff @(posedge clk) begin
			if (in_fire) begin
				raw_s1[k]  <= raw_d[k];
				frac_s1[k] <= frac_d[k];
				hit_s1[k]  <= wr[k].en && (wr[k].row == row_d);
				fwd_s1[k]  <= wr[k].data;
			end else if (wr[k].en && (wr[k].row == row_s1)) begin
				hit_s1[k]  <= 1'b1;
				fwd_s1[k]  <= wr[k].data;
			end
			if (s1_move) begin
				raw6_s2[k] <= ScaledW'(raw_s1[k]) * ScaledW'(6);
				quot_s2[k] <= prod_s1[k][RecipShift +: QuotW];
				old_s2[k]  <= (wr[k].en && (wr[k].row == row_s1)) ? wr[k].data : old_s1[k];
			end
			if (s2_move) begin
				stored_q[k] <= ok_s2 ? stored[k] : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ok_s1  <= ok_d;
			mod_s1 <= mod_d;
			sel_s1 <= frame_id[4];
			row_s1 <= row_d;
		end
		if (s1_move) begin
			ok_s2  <= ok_s1;
			mod_s2 <= mod_s1;
			sel_s2 <= sel_s1;
			row_s2 <= row_s1;
		end
		if (s2_move) begin
			accepted_q      <= ok_s2;
			module_number_q <= ok_s2 ? mod_s2 : '0;
			first_cell_q    <= ok_s2 ? {sel_s2, 2'b00} : '0;
			updated_mask_q  <= in_rng;
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign module_number = module_number_q;
	assign first_cell    = first_cell_q;
	assign updated_mask  = updated_mask_q;
	assign stored_value0 = stored_q[0];
	assign stored_value1 = stored_q[1];
	assign stored_value2 = stored_q[2];
	assign stored_value3 = stored_q[3];

endmodule

FILE: design/cvfa_bank.sv
module cvfa_bank (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic [cvfa_pkg::RowW-1:0]      rd_row,
	input  cvfa_pkg::cvfa_wr_t             wr,
	output logic [cvfa_pkg::VoltW-1:0]     rd_data
);
	import cvfa_pkg::*;

	logic [VoltW-1:0]    mem [BankRows];
	logic [BankRows-1:0] vld_q;
	logic [VoltW-1:0]    rd_q;
	logic                rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.row] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_row];
		end
	end

	// an entry never written reads as an empty cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.row] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_row];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

FILE: design/cvfa_checker.sv
module cvfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        accepted,
	input logic [3:0]  module_number,
	input logic [2:0]  first_cell,
	input logic [3:0]  updated_mask,
	input logic [15:0] stored_value0,
	input logic [15:0] stored_value1,
	input logic [15:0] stored_value2,
	input logic [15:0] stored_value3
);
	import cvfa_pkg::*;

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> module_number == '0 && first_cell == '0
			&& updated_mask == '0 && stored_value0 == '0 && stored_value1 == '0
			&& stored_value2 == '0 && stored_value3 == '0)
		else $error("rejected frame beat carries nonzero fields");

	a_decode_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> 32'(module_number) < ModuleCount
			&& (first_cell == 3'd0 || first_cell == 3'd4))
		else $error("module or first cell out of range");

	a_update_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!updated_mask[0] || stored_value0 != '0)
			&& (!updated_mask[1] || stored_value1 != '0)
			&& (!updated_mask[2] || stored_value2 != '0)
			&& (!updated_mask[3] || stored_value3 != '0))
		else $error("updated cell reads as empty");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(accepted)
			&& $stable(module_number) && $stable(first_cell) && $stable(updated_mask)
			&& $stable(stored_value0) && $stable(stored_value1)
			&& $stable(stored_value2) && $stable(stored_value3))
		else $error("stalled output beat changed");

endmodule

bind cell_voltage_frame_averager cvfa_checker u_cvfa_checker (.*);
